// File: rtl/core/zigzag_varint_stream_decoder_macros.svh
// Assertion macros used by the checker file.
`ifndef ZIGZAG_VARINT_STREAM_DECODER_MACROS_SVH
`define ZIGZAG_VARINT_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, off during reset.
`define ZVD_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zvd check failed");

// Next-cycle implication, off during reset.
`define ZVD_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zvd check failed");

// Next-cycle implication, live during reset too.
`define ZVD_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("zvd check failed");

`endif

// File: rtl/core/zvd_pkg.sv
`timescale 1ns / 1ps
package zvd_pkg;

  localparam int LENGTH_BITS_DEF  = 32;
  localparam int VALUE_BITS       = 64;
  localparam int GROUP_BITS       = 7;
  localparam int CONT_BIT         = 7;
  localparam int COUNT_BITS       = 4;
  localparam int SHIFT_BITS       = 7;
  localparam logic [COUNT_BITS-1:0] VARINT_MAX_BYTES = 4'd10;

  typedef enum logic [1:0] {
    KIND_LONG  = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef struct packed {
    logic done;      // byte ends the varint
    logic overlong;  // byte would be the eleventh of one varint
  } varint_status_t;

endpackage

// File: rtl/core/zvd_varint.sv
`timescale 1ns / 1ps
module zvd_varint
  import zvd_pkg::*;
(
  input  logic [VALUE_BITS-1:0] gathered,
  input  logic [COUNT_BITS-1:0] count,
  input  logic [7:0]            stream_byte,
  output logic [VALUE_BITS-1:0] gathered_next,
  output logic [COUNT_BITS-1:0] count_next,
  output logic [VALUE_BITS-1:0] value,
  output varint_status_t        status
);

  logic [SHIFT_BITS-1:0] shift_amt;
  logic [VALUE_BITS-1:0] group;

  // Place the seven new bits above those already gathered; the tenth byte
  // keeps only its low bit.
  assign shift_amt     = SHIFT_BITS'(count) * SHIFT_BITS'(GROUP_BITS);
  assign group         = VALUE_BITS'(stream_byte[GROUP_BITS-1:0]) << shift_amt;
  assign gathered_next = gathered | group;
  assign count_next    = count + COUNT_BITS'(1);

  // Zigzag: (g >> 1) ^ -(g & 1).
  assign value = (gathered_next >> 1) ^ {VALUE_BITS{gathered_next[0]}};

  assign status.done     = ~stream_byte[CONT_BIT];
  assign status.overlong = (count >= VARINT_MAX_BYTES);

endmodule

// File: rtl/core/zigzag_varint_stream_decoder.sv
// An accepted byte that yields a result has it registered on the output in the next cycle.
// Throughput: one byte per cycle; in_stall rises only while the single
// result register holds an item that the far side is stalling.
// Reset (rst, synchronous, active high) clears the varint state, the
// string payload state, string_mode and the result register valid.
`timescale 1ns / 1ps
module zigzag_varint_stream_decoder
  import zvd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data,
  // input byte channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   stream_byte,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   kind,
  output logic signed [VALUE_BITS-1:0] long_value,
  output logic [7:0]                   payload_byte,
  output logic                         last_of_string
);

  // Decoder state.
  logic [VALUE_BITS-1:0]  gathered_bits;
  logic [COUNT_BITS-1:0]  varint_byte_count;
  logic                   in_payload;
  logic [LENGTH_BITS-1:0] payload_left;
  logic                   string_mode;

  logic [VALUE_BITS-1:0]  gathered_bits_next;
  logic [COUNT_BITS-1:0]  varint_byte_count_next;
  logic                   in_payload_next;
  logic [LENGTH_BITS-1:0] payload_left_next;

  // Result computed for the byte on the input this cycle.
  logic                   res_valid;
  kind_t                  res_kind;
  logic [VALUE_BITS-1:0]  res_value;
  logic [7:0]             res_byte;
  logic                   res_last;

  logic                   accept;
  logic [VALUE_BITS-1:0]  vi_gathered;
  logic [COUNT_BITS-1:0]  vi_count;
  logic [VALUE_BITS-1:0]  vi_value;
  varint_status_t         vi_status;
  logic [LENGTH_BITS-1:0] left_dec;

  // Take a write in any cycle; the mode is sampled only when a varint
  // finishes, so a payload under way runs to its end.
  assign cfg_ready = 1'b1;

  // Take a byte unless the result register is full and held.
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  zvd_varint u_varint (
    .gathered      (gathered_bits),
    .count         (varint_byte_count),
    .stream_byte   (stream_byte),
    .gathered_next (vi_gathered),
    .count_next    (vi_count),
    .value         (vi_value),
    .status        (vi_status)
  );

  assign left_dec = payload_left - LENGTH_BITS'(1);

  always_comb begin
    gathered_bits_next     = gathered_bits;
    varint_byte_count_next = varint_byte_count;
    in_payload_next        = in_payload;
    payload_left_next      = payload_left;
    res_valid              = 1'b0;
    res_kind               = KIND_LONG;
    res_value              = '0;
    res_byte               = '0;
    res_last               = 1'b0;

    if (in_payload) begin
      // Pass the payload byte through; the count reaching zero marks last.
      payload_left_next = left_dec;
      res_valid         = 1'b1;
      res_kind          = KIND_BYTE;
      res_byte          = stream_byte;
      res_last          = (left_dec == '0);
      if (left_dec == '0) begin
        in_payload_next = 1'b0;
      end
    end else if (vi_status.overlong) begin
      // Too many varint bytes: drop this one, flag it and start over.
      gathered_bits_next     = '0;
      varint_byte_count_next = '0;
      res_valid              = 1'b1;
      res_kind               = KIND_ERROR;
    end else begin
      gathered_bits_next     = vi_gathered;
      varint_byte_count_next = vi_count;
      if (vi_status.done) begin
        gathered_bits_next     = '0;
        varint_byte_count_next = '0;
        if (!string_mode) begin
          res_valid = 1'b1;
          res_kind  = KIND_LONG;
          res_value = vi_value;
        end else if (vi_value[VALUE_BITS-1:LENGTH_BITS] != '0) begin
          // Negative length or one wider than the payload counter.
          res_valid = 1'b1;
          res_kind  = KIND_ERROR;
        end else if (vi_value == '0) begin
          res_valid = 1'b1;
          res_kind  = KIND_EMPTY;
        end else begin
          in_payload_next   = 1'b1;
          payload_left_next = vi_value[LENGTH_BITS-1:0];
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      gathered_bits     <= '0;
      varint_byte_count <= '0;
      in_payload        <= 1'b0;
      payload_left      <= '0;
      string_mode       <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        string_mode <= cfg_data;
      end
      if (accept) begin
        gathered_bits     <= gathered_bits_next;
        varint_byte_count <= varint_byte_count_next;
        in_payload        <= in_payload_next;
        payload_left      <= payload_left_next;
      end
      // Load a new result or drop a taken one; hold while stalled.
      if (!in_stall) begin
        out_valid <= accept & res_valid;
      end
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      kind           <= res_kind;
      long_value     <= res_value;
      payload_byte   <= res_byte;
      last_of_string <= res_last;
    end
  end

endmodule

// File: rtl/core/zvd_checker.sv
`timescale 1ns / 1ps
`include "zigzag_varint_stream_decoder_macros.svh"
module zvd_checker
  import zvd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [1:0]            kind,
  input logic [VALUE_BITS-1:0] long_value,
  input logic [7:0]            payload_byte,
  input logic                  last_of_string
);

  `ZVD_NEXT_ALWAYS(a_reset_empties, rst, !out_valid)
  `ZVD_IMPLY(a_stall_only_when_full, in_stall, out_valid && out_stall)
  `ZVD_NEXT(a_held_result, out_valid && out_stall, out_valid && $stable(kind) && $stable(long_value) && $stable(payload_byte) && $stable(last_of_string))
  `ZVD_IMPLY(a_empty_clean, out_valid && (kind == KIND_EMPTY), (long_value == '0) && (payload_byte == '0) && !last_of_string)

endmodule

bind zigzag_varint_stream_decoder zvd_checker u_zvd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .kind           (kind),
  .long_value     (long_value),
  .payload_byte   (payload_byte),
  .last_of_string (last_of_string)
);
